// ----- src/bhq_pkg.sv -----
// Package for the binary min-heap queue: sizes, entry type, status codes,
// sequencer states. Used by the top level and bhq_cmp; depends on nothing.
package bhq_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CHILD_W  = ADDR_W + 2;
  localparam int ID_W     = 16;
  localparam int KEY_W    = 32;
  localparam int OCC_W    = 11;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_POP_LD,
    S_DN_RD,
    S_DN_CMP
  } state_t;

  // Compare unit request and answer
  typedef struct packed {
    logic             down;
    logic [KEY_W-1:0] item_key;
    logic [KEY_W-1:0] key_a;
    logic [KEY_W-1:0] key_b;
    logic             a_ok;
    logic             b_ok;
  } cmp_req_t;

  typedef struct packed {
    logic move;
    logic pick_b;
  } cmp_res_t;

endpackage

// ----- src/binary_min_heap_queue.sv -----
// Top level of the binary min-heap priority queue: sequencer, entry count,
// result registers. Depends on bhq_pkg, bhq_ram and bhq_cmp.
//
//  channel  | signals                                 | transfer
//  ---------+-----------------------------------------+-------------------------
//  command  | start, busy, func, item_id, item_key    | start high and busy low
//  result   | done, status, out_id, out_key, occupancy| done high, one cycle
//
// A full push or an empty pop answers in the cycle after the command. Each sift level is
// the registered RAM read, then the compare and write-back. A push climbs until it
// reaches the root or a parent stops it; a pop descends from the root until no
// child is smaller.
// rst is synchronous; it empties the heap, the RAM contents stay as they are.
// The receiver cannot stall: each result is shown for exactly one cycle, busy already low.
module binary_min_heap_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        func,
  input  logic [bhq_pkg::ID_W-1:0]    item_id,
  input  logic [bhq_pkg::KEY_W-1:0]   item_key,
  output logic                        done,
  output logic [1:0]                  status,
  output logic [bhq_pkg::ID_W-1:0]    out_id,
  output logic [bhq_pkg::KEY_W-1:0]   out_key,
  output logic [bhq_pkg::OCC_W-1:0]   occupancy
);
  import bhq_pkg::*;

  state_t             state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [ADDR_W-1:0]  pos, pos_next;
  entry_t             item, item_next;
  logic               done_next;
  status_t            res_status, res_status_next;
  logic [ID_W-1:0]    res_id, res_id_next;
  logic [KEY_W-1:0]   res_key, res_key_next;

  // RAM ports
  logic               we;
  logic [ADDR_W-1:0]  waddr;
  entry_t             wdata;
  logic [ADDR_W-1:0]  raddr_a, raddr_b;
  entry_t             rdata_a, rdata_b;

  // Tree addressing
  logic [ADDR_W-1:0]  parent;
  logic [CHILD_W-1:0] left, right;

  cmp_req_t           req;
  cmp_res_t           res;

  bhq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  bhq_cmp u_cmp (
    .req (req),
    .res (res)
  );

  assign parent = (pos - ADDR_W'(1)) >> 1;
  assign left   = CHILD_W'({pos, 1'b0}) + CHILD_W'(1);
  assign right  = CHILD_W'({pos, 1'b0}) + CHILD_W'(2);

  always_comb begin
    req.down     = (state == S_DN_CMP);
    req.item_key = item.key;
    req.key_a    = rdata_a.key;
    req.key_b    = rdata_b.key;
    // Children past the last entry hold stale data: mask them off.
    req.a_ok     = left < CHILD_W'(count);
    req.b_ok     = right < CHILD_W'(count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    pos        <= pos_next;
    item       <= item_next;
    res_status <= res_status_next;
    res_id     <= res_id_next;
    res_key    <= res_key_next;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    pos_next        = pos;
    item_next       = item;
    done_next       = 1'b0;
    res_status_next = res_status;
    res_id_next     = res_id;
    res_key_next    = res_key;
    we              = 1'b0;
    waddr           = pos;
    wdata           = item;
    // Idle default reads root and last entry, ready for a pop.
    raddr_a         = '0;
    raddr_b         = ADDR_W'(count - CNT_W'(1));

    unique case (state)
      S_IDLE: begin
        if (start) begin
          res_status_next = ST_OK;
          res_id_next     = '0;
          res_key_next    = '0;
          if (func == FUNC_PUSH) begin
            if (count == CNT_W'(CAPACITY)) begin
              res_status_next = ST_FULL;
              done_next       = 1'b1;
            end else begin
              item_next  = '{id: item_id, key: item_key};
              pos_next   = ADDR_W'(count);
              count_next = count + CNT_W'(1);
              state_next = S_UP_RD;
            end
          end else begin
            if (count == '0) begin
              res_status_next = ST_EMPTY;
              done_next       = 1'b1;
            end else begin
              state_next = S_POP_LD;
            end
          end
        end
      end

      S_UP_RD: begin
        if (pos == '0) begin
          we         = 1'b1;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          raddr_a    = parent;
          state_next = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        we = 1'b1;
        if (res.move) begin
          // Drop the parent into the hole and climb.
          wdata      = rdata_a;
          pos_next   = parent;
          state_next = S_UP_RD;
        end else begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_POP_LD: begin
        res_id_next  = rdata_a.id;
        res_key_next = rdata_a.key;
        item_next    = rdata_b;
        count_next   = count - CNT_W'(1);
        pos_next     = '0;
        state_next   = S_DN_RD;
      end

      S_DN_RD: begin
        raddr_a    = left[ADDR_W-1:0];
        raddr_b    = right[ADDR_W-1:0];
        state_next = S_DN_CMP;
      end

      S_DN_CMP: begin
        we = 1'b1;
        if (res.move) begin
          // Lift the smaller child into the hole and descend.
          wdata      = res.pick_b ? rdata_b : rdata_a;
          pos_next   = res.pick_b ? right[ADDR_W-1:0] : left[ADDR_W-1:0];
          state_next = S_DN_RD;
        end else begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy      = (state != S_IDLE);
  assign status    = res_status;
  assign out_id    = res_id;
  assign out_key   = res_key;
  assign occupancy = OCC_W'(count);

endmodule

// ----- src/bhq_ram.sv -----
// Generic RAM: one write port, two read ports, registered read data.
// Self-contained; no package needed.
module bhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- src/bhq_cmp.sv -----
// Shared key compare unit for sift-up and sift-down decisions.
// Depends on bhq_pkg.
module bhq_cmp (
  input  bhq_pkg::cmp_req_t req,
  output bhq_pkg::cmp_res_t res
);
  import bhq_pkg::*;

  logic             take_a;
  logic [KEY_W-1:0] best_key;
  logic             take_b;

  always_comb begin
    // Sift-down: left child wins ties, so the right child must be strictly smaller.
    take_a   = req.a_ok && (req.key_a < req.item_key);
    best_key = take_a ? req.key_a : req.item_key;
    take_b   = req.b_ok && (req.key_b < best_key);
    if (req.down) begin
      res.move   = take_a || take_b;
      res.pick_b = take_b;
    end else begin
      // Sift-up: move the parent down while its key is strictly greater.
      res.move   = req.key_a > req.item_key;
      res.pick_b = 1'b0;
    end
  end

endmodule
